// ----- design/sha256_pkg.sv -----
// sha256_pkg: SHA-256 constants and round functions.
// Used by sha256_stream_hash; no dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int LEN_OFFSET  = 56;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ----- design/sha256_msg_if.sv -----
// sha256_msg_if: message byte channel, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface sha256_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

// ----- design/sha256_dig_if.sv -----
// sha256_dig_if: digest word channel, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface sha256_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ----- design/sha256_stream_hash.sv -----
// sha256_stream_hash: streaming SHA-256, at most one message byte per request.
// Depends on sha256_pkg, sha256_msg_if, sha256_dig_if.
//
//   channel  dir  payload                                   requests
//   msg      in   data_byte, byte_present, end_of_message   one byte (or none) each
//   digest   out  digest_word, word_index, last_word        eight per finished message
//
// A byte that does not complete a 64-byte block is simply stored. A byte that
// completes a block is stored, then the 64 rounds run on the single round unit
// (one round per cycle), then the result is folded into the chaining words; no
// new byte is taken until that is done.
// Finishing feeds the pad byte, zeros and the bit length one byte per cycle
// through the same block register: with n <= 55 bytes buffered, the pad byte
// and zeros up to byte 56, a switch to the length, the 8 length bytes, then
// compression. With 56..63 buffered, the pad byte and zeros fill the block and
// it is compressed first, then a second block of zeros and the length follows.
// Eight digest requests follow.
// msg.ready is low throughout; the digest channel may stall freely.
// arst_n restores the initial chaining words and clears all counts.
`timescale 1ns / 1ps
module sha256_stream_hash (
	input  logic          clk,
	input  logic          arst_n,
	sha256_msg_if.sink    msg,
	sha256_dig_if.source  digest
);
	import sha256_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROUND = 6'b000010,
		S_ADD   = 6'b000100,
		S_PAD   = 6'b001000,
		S_LEN   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [6:0]    fill_q;        // bytes held in the block register, 0..64
	logic [63:0]   byte_count_q;  // message bytes; shifted as bit length in S_LEN
	logic          finish_q;      // current message is being finished
	logic          mark_q;        // 0x80 already appended
	logic          last_q;        // block being compressed is the final one
	logic [5:0]    round_q;
	logic [2:0]    widx_q;
	logic [31:0]   hash_q [8];
	logic [31:0]   v_q [8];       // working variables a..h
	logic [511:0]  win_q;         // block bytes, later the 16-word schedule window

	logic          msg_fire;
	logic          dig_fire;
	logic          push_en;
	logic [7:0]    push_byte;
	logic          block_full;
	logic [31:0]   w_t;
	logic [31:0]   w_new;
	logic [31:0]   t1;
	logic [31:0]   t2;

	assign msg.ready = (state_q == S_IDLE);
	assign msg_fire  = msg.valid & msg.ready;

	assign digest.valid       = (state_q == S_EMIT);
	assign digest.digest_word = hash_q[widx_q];
	assign digest.word_index  = widx_q;
	assign digest.last_word   = (widx_q == 3'd7);
	assign dig_fire           = digest.valid & digest.ready;

	// One byte a cycle enters the block register while push_en is high: message
	// bytes from the channel, or padding and length bytes while finishing.
	always_comb begin
		push_en   = 1'b0;
		push_byte = msg.data_byte;
		case (state_q)
			S_IDLE: begin
				push_en = msg_fire & msg.byte_present;
			end
			S_PAD: begin
				push_en   = !(mark_q && (fill_q == 7'(LEN_OFFSET)));
				push_byte = mark_q ? 8'h00 : PAD_MARK;
			end
			S_LEN: begin
				push_en   = 1'b1;
				push_byte = byte_count_q[60:53];  // top byte of count * 8
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign block_full = push_en && (fill_q == 7'(BLOCK_BYTES - 1));

	// Round unit: schedule word and the two round sums.
	assign w_t   = win_q[511:480];
	assign w_new = w_t + small_sigma0(win_q[479:448]) + win_q[223:192]
		+ small_sigma1(win_q[63:32]);
	assign t1    = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[round_q] + w_t;
	assign t2    = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

	// Control and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			byte_count_q <= '0;
			finish_q     <= 1'b0;
			mark_q       <= 1'b0;
			last_q       <= 1'b0;
			round_q      <= '0;
			widx_q       <= '0;
			hash_q       <= HASH_INIT;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 7'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (msg_fire) begin
						if (msg.byte_present) begin
							byte_count_q <= byte_count_q + 64'd1;
						end
						if (block_full) begin
							finish_q <= msg.end_of_message;
							state_q  <= S_ROUND;
						end else if (msg.end_of_message) begin
							finish_q <= 1'b1;
							state_q  <= S_PAD;
						end
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					fill_q <= '0;
					if (last_q) begin
						state_q <= S_EMIT;
					end else if (finish_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end
					if (block_full) begin
						state_q <= S_ROUND;
					end else if (mark_q && (fill_q == 7'(LEN_OFFSET))) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					byte_count_q <= {byte_count_q[55:0], 8'h00};
					if (block_full) begin
						last_q  <= 1'b1;
						state_q <= S_ROUND;
					end
				end
				S_EMIT: begin
					if (dig_fire) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							hash_q       <= HASH_INIT;
							fill_q       <= '0;
							byte_count_q <= '0;
							finish_q     <= 1'b0;
							mark_q       <= 1'b0;
							last_q       <= 1'b0;
							state_q      <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Block register and working variables
	always_ff @(posedge clk) begin
		if (push_en) begin
			win_q <= {win_q[503:0], push_byte};
		end else if (state_q == S_ROUND) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (block_full) begin
			v_q <= hash_q;
		end else if (state_q == S_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ----- bench/sha256_stream_hash_test.sv -----
// sha256_stream_hash_test: self-checking bench for the streaming SHA-256 block.
// Depends on sha256_msg_if, sha256_dig_if and sha256_stream_hash; keeps its own hash model.
`timescale 1ns / 1ps
module sha256_stream_hash_test;

	// One message request as queued for the driver. hold_for_drain makes the
	// driver wait until every outstanding digest word has been collected.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
		logic       hold_for_drain;
	} msg_req_t;

	// One digest word as predicted.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        last;
	} digest_word_t;

	// Round constants and initial chaining words, packed with entry 0 at the top.
	localparam logic [64*32-1:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [8*32-1:0] CHAIN_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam int         LEN_FIELD  = 56;   // first byte of the length field
	localparam int         ITEM_COUNT = 310;  // at least this many requests, idle ones too
	localparam int         SETTLE_CYCLES = 300; // longer than a two-block finish

	logic clk;
	logic arst_n;

	sha256_msg_if msg ();
	sha256_dig_if digest ();

	sha256_stream_hash u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	// Requests still to be offered, and digest words still owed by the block.
	msg_req_t     pending_reqs[$];
	digest_word_t digest_due[$];

	int err_count;
	int n_items;
	int n_msgs;
	logic req_taken;

	// Hash model state: chaining words, partial block (byte 0 at the top),
	// fill level and the running message length in bytes.
	logic [8*32-1:0] chain;
	logic [511:0]    blk_buf;
	int              blk_fill;
	logic [63:0]     msg_len;

	// ---------------------------------------------------------------- clock, reset
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		msg.valid = 1'b0;
		msg.data_byte = 8'h00;
		msg.byte_present = 1'b0;
		msg.end_of_message = 1'b0;
		digest.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- hash model
	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of a 512-bit block into the chaining words.
	task automatic compress_into_chain(input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = blk[511 - 32*i -: 32];
		for (i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (i = 0; i < 8; i++)
			v[i] = chain[255 - 32*i -: 32];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[2047 - 32*i -: 32] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + v[i];
	endtask

	task automatic clear_hash_state();
		chain = CHAIN_INIT;
		blk_buf = '0;
		blk_fill = 0;
		msg_len = '0;
	endtask

	// Apply one accepted request to the model; a finishing request queues
	// the eight digest words, most significant first.
	task automatic hash_request(input msg_req_t r);
		logic [511:0] tail;
		digest_word_t dw;
		int j;
		if (r.byte_present) begin
			blk_buf[511 - 8*blk_fill -: 8] = r.data_byte;
			blk_fill++;
			msg_len++;
			if (blk_fill == 64) begin
				compress_into_chain(blk_buf);
				blk_fill = 0;
			end
		end
		if (r.end_of_message) begin
			// keep only the buffered bytes, then the marker byte
			tail = blk_buf & ({512{1'b1}} << (512 - 8*blk_fill));
			tail[511 - 8*blk_fill -: 8] = PAD_BYTE;
			if (blk_fill + 1 > LEN_FIELD) begin
				compress_into_chain(tail);
				tail = '0;
			end
			tail[63:0] = msg_len << 3;
			compress_into_chain(tail);
			for (j = 0; j < 8; j++) begin
				dw.word = chain[255 - 32*j -: 32];
				dw.pos = 3'(j);
				dw.last = (j == 7);
				digest_due.insert(digest_due.size(), dw);
			end
			clear_hash_state();
		end
	endtask

	// ---------------------------------------------------------------- stimulus build
	task automatic add_req(input logic [7:0] d, input logic present, input logic eom,
			input logic hold);
		msg_req_t r;
		r.data_byte = d;
		r.byte_present = present;
		r.end_of_message = eom;
		r.hold_for_drain = hold;
		pending_reqs.insert(pending_reqs.size(), r);
		n_items++;
	endtask

	// A message of len random bytes, with stray idle requests mixed in. It is
	// finished either on its last byte or by a separate empty finishing request.
	task automatic queue_message(input int len, input logic hold);
		logic split_finish;
		int i;
		split_finish = (len == 0) || ($urandom_range(0, 3) == 0);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				add_req(8'($urandom), 1'b0, 1'b0, 1'b0);
			add_req(8'($urandom), 1'b1, !split_finish && (i == len - 1),
				hold && (i == 0));
		end
		if (split_finish)
			add_req(8'($urandom), 1'b0, 1'b1, hold && (len == 0));
		n_msgs++;
	endtask

	// ---------------------------------------------------------------- mismatch report
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	// ---------------------------------------------------------------- driver
	// Requests go out at the falling edge. The sender runs in bursts of random
	// length with random gaps; a request marked for draining waits until the
	// block has handed over every digest word still owed.
	int burst_left;
	int gap_left;

	always @(negedge clk) begin
		if (arst_n && (!msg.valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				msg.valid <= 1'b0;
			end else if (pending_reqs.size() == 0 ||
					(pending_reqs[0].hold_for_drain && digest_due.size() != 0)) begin
				msg.valid <= 1'b0;
			end else begin
				msg.data_byte <= pending_reqs[0].data_byte;
				msg.byte_present <= pending_reqs[0].byte_present;
				msg.end_of_message <= pending_reqs[0].end_of_message;
				msg.valid <= 1'b1;
				void'(pending_reqs.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
		end
	end

	// Digest receiver: ready steps through the bits of a random 16-bit mask, which
	// is redrawn periodically; about a quarter of the masks never stall.
	logic [15:0] stall_mask;
	int          rx_cycle;

	always @(negedge clk) begin
		if (!arst_n) begin
			digest.ready <= 1'b0;
		end else begin
			if (rx_cycle % 64 == 0) begin
				stall_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
				if (stall_mask == 16'h0000)
					stall_mask = 16'h0001;
			end
			digest.ready <= stall_mask[rx_cycle % 16];
			rx_cycle++;
		end
	end

	// ---------------------------------------------------------------- monitor
	// At each rising edge: digest words are checked against the oldest
	// prediction first, then any accepted request is fed to the model, so a
	// word cannot be matched against a request taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		digest_word_t want;
		msg_req_t     got_req;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (digest.valid && digest.ready) begin
				if (digest_due.size() == 0) begin
					report_mismatch("digest_word with no finished message",
						digest.digest_word, 32'h0000_0000);
				end else begin
					want = digest_due.pop_front();
					if (digest.digest_word !== want.word)
						report_mismatch("digest_word", digest.digest_word, want.word);
					if (digest.word_index !== want.pos)
						report_mismatch("word_index", 32'(digest.word_index), 32'(want.pos));
					if (digest.last_word !== want.last)
						report_mismatch("last_word", 32'(digest.last_word), 32'(want.last));
				end
			end
			if (msg.valid && msg.ready) begin
				got_req.data_byte = msg.data_byte;
				got_req.byte_present = msg.byte_present;
				got_req.end_of_message = msg.end_of_message;
				got_req.hold_for_drain = 1'b0;
				hash_request(got_req);
			end
			req_taken <= msg.valid && msg.ready;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		int len;
		int pick;
		int room;
		err_count = 0;
		n_items = 0;
		n_msgs = 0;
		burst_left = 1;
		gap_left = 0;
		rx_cycle = 0;
		stall_mask = 16'hffff;
		clear_hash_state();

		// Directed: empty message, idle request, "abc", single bytes at both
		// extremes, a byte finished by an empty request, the marker value itself.
		add_req(8'h00, 1'b0, 1'b1, 1'b0);
		add_req(8'ha5, 1'b0, 1'b0, 1'b0);
		add_req(8'h61, 1'b1, 1'b0, 1'b0);
		add_req(8'h62, 1'b1, 1'b0, 1'b0);
		add_req(8'h63, 1'b1, 1'b1, 1'b0);
		add_req(8'h00, 1'b1, 1'b1, 1'b0);
		add_req(8'hff, 1'b1, 1'b0, 1'b0);
		add_req(8'hff, 1'b0, 1'b1, 1'b0);
		add_req(8'hff, 1'b0, 1'b0, 1'b0);
		add_req(8'h80, 1'b1, 1'b1, 1'b0);

		// Random messages: many short, many around the one- and two-block
		// padding boundaries, some long. The first waits for a full drain.
		while (n_items < ITEM_COUNT) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				len = $urandom_range(0, 12);
			end else if (pick < 7) begin
				case ($urandom_range(0, 9))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					6: len = 119;
					7: len = 120;
					8: len = 127;
					default: len = 128;
				endcase
			end else begin
				len = $urandom_range(0, 140);
			end
			room = ITEM_COUNT - n_items;
			if (len > room)
				len = room;
			queue_message(len, (n_msgs == 0) || ($urandom_range(0, 19) == 0));
		end

		// Every request accepted, every digest word collected, then a quiet
		// spell to catch stray words.
		@(posedge arst_n);
		while (pending_reqs.size() != 0 || msg.valid)
			@(negedge clk);
		while (digest_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
